FILE: rtl/hms_pkg.sv
// Shared types, constants and tables of the halftone mark sizer.
package hms_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 18;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_CONTROL    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_GLOW_WIDTH = 3'd1;
  localparam logic [CFG_AW-1:0] REG_TONE       = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GAMMA      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MIN_SIZE   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_MAX_SIZE   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_CULL_SIZE  = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPACING    = 3'd7;

  // Reset values
  localparam logic [7:0]  RST_CONTROL    = 8'd0;
  localparam logic [15:0] RST_GLOW_WIDTH = 16'd2560;
  localparam logic [17:0] RST_TONE       = 18'd166656;
  localparam logic [11:0] RST_GAMMA      = 12'd256;
  localparam logic [15:0] RST_MIN_SIZE   = 16'd0;
  localparam logic [15:0] RST_MAX_SIZE   = 16'd1536;
  localparam logic [15:0] RST_CULL_SIZE  = 16'd0;
  localparam logic [15:0] RST_SPACING    = 16'd2048;

  // Shape codes
  localparam logic [2:0] SHAPE_CIRCLE   = 3'd0;
  localparam logic [2:0] SHAPE_SQUARE   = 3'd1;
  localparam logic [2:0] SHAPE_DIAMOND  = 3'd2;
  localparam logic [2:0] SHAPE_TRIANGLE = 3'd3;
  localparam logic [2:0] SHAPE_HEXAGON  = 3'd4;
  localparam logic [2:0] SHAPE_STAR     = 3'd5;
  localparam logic [2:0] SHAPE_LINE     = 3'd6;

  // Drop reasons
  typedef logic [2:0] drop_t;
  localparam drop_t DROP_NONE   = 3'd0;
  localparam drop_t DROP_BOUNDS = 3'd1;
  localparam drop_t DROP_SIDE   = 3'd2;
  localparam drop_t DROP_GLOW   = 3'd3;
  localparam drop_t DROP_CULL   = 3'd4;
  localparam drop_t DROP_SMALL  = 3'd5;

  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [15:0] SMALL_LIMIT = 16'd12;      // 0.05 point
  localparam logic [15:0] CORE_SPACE_K = 16'd29491;  // 0.45 of spacing
  localparam logic [15:0] CORE_GLOW_K  = 16'd41943;  // 0.64 of glow width
  localparam logic [16:0] SQUARE_LIM_K = 17'd92682;  // sqrt(2)

  typedef struct packed {
    logic [2:0]  shape;
    logic        glow;
    logic        invert;
    logic        solid;
    logic        contain;
    logic        clip;
    logic [15:0] weff;        // glow width, zero taken as one LSB
    logic [8:0]  strength;
    logic [8:0]  softness;    // saturated to one
    logic [11:0] gamma;
    logic [15:0] min_size;
    logic [15:0] max_size;
    logic [15:0] cull_size;
    logic [31:0] core_thresh;
    logic [15:0] core_raise;
  } cfg_t;

  typedef struct packed {
    logic [15:0] d;
    drop_t       reason;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [16:0] den;
  } dens_t;

  function automatic logic [17:0] core_mult(logic [2:0] shape);
    case (shape)
      SHAPE_CIRCLE:   return 18'd119276;
      SHAPE_SQUARE:   return 18'd112722;
      SHAPE_DIAMOND:  return 18'd137626;
      SHAPE_TRIANGLE: return 18'd160563;
      SHAPE_HEXAGON:  return 18'd112722;
      SHAPE_STAR:     return 18'd167117;
      SHAPE_LINE:     return 18'd154010;
      default:        return 18'd124518;
    endcase
  endfunction

  // Floor square root, used only to build the root table below.
  function automatic logic [63:0] isqrt64(logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v = val;
    res = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Root n is 2^(-2^-(n+1)) in Q0.32, each the floor root of the one before.
  function automatic logic [31:0] exp_root(int n);
    logic [63:0] r;
    r = isqrt64(64'h8000_0000_0000_0000);
    for (int i = 0; i < n; i++) r = isqrt64({r[31:0], 32'h0});
    return r[31:0];
  endfunction

  localparam logic [31:0] EXP_ROOT [16] = '{
    exp_root(0),  exp_root(1),  exp_root(2),  exp_root(3),
    exp_root(4),  exp_root(5),  exp_root(6),  exp_root(7),
    exp_root(8),  exp_root(9),  exp_root(10), exp_root(11),
    exp_root(12), exp_root(13), exp_root(14), exp_root(15)
  };

endpackage

FILE: rtl/hms_if.sv
// Point and mark channel interfaces of the halftone mark sizer.
interface hms_point_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance_to_edge;
  logic        point_inside;
  logic        within_bounds;

  modport source (output valid, distance_to_edge, point_inside, within_bounds, input ready);
  modport sink   (input valid, distance_to_edge, point_inside, within_bounds, output ready);
endinterface

interface hms_mark_if;
  logic        valid;
  logic        ready;
  logic [15:0] mark_size;
  logic [2:0]  drop_reason;

  modport source (output valid, mark_size, drop_reason, input ready);
  modport sink   (input valid, mark_size, drop_reason, output ready);
endinterface

FILE: rtl/hms_cfg.sv
// Configuration registers and derived solid core values.
module hms_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [hms_pkg::CFG_AW-1:0] cfg_index,
  input  logic [hms_pkg::CFG_DW-1:0] cfg_data,
  output hms_pkg::cfg_t             cfg
);
  import hms_pkg::*;

  logic [7:0]  control;
  logic [15:0] glow_width;
  logic [17:0] tone_controls;
  logic [11:0] gamma;
  logic [15:0] min_size;
  logic [15:0] max_size;
  logic [15:0] cull_size;
  logic [15:0] spacing;
  logic [31:0] core_thresh;
  logic [15:0] core_raise;

  logic [15:0] weff;
  logic [8:0]  soft_raw;
  logic [31:0] thr_space;
  logic [31:0] thr_glow;
  logic [33:0] raise_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      control       <= RST_CONTROL;
      glow_width    <= RST_GLOW_WIDTH;
      tone_controls <= RST_TONE;
      gamma         <= RST_GAMMA;
      min_size      <= RST_MIN_SIZE;
      max_size      <= RST_MAX_SIZE;
      cull_size     <= RST_CULL_SIZE;
      spacing       <= RST_SPACING;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CONTROL:    control       <= cfg_data[7:0];
        REG_GLOW_WIDTH: glow_width    <= cfg_data[15:0];
        REG_TONE:       tone_controls <= cfg_data[17:0];
        REG_GAMMA:      gamma         <= cfg_data[11:0];
        REG_MIN_SIZE:   min_size      <= cfg_data[15:0];
        REG_MAX_SIZE:   max_size      <= cfg_data[15:0];
        REG_CULL_SIZE:  cull_size     <= cfg_data[15:0];
        REG_SPACING:    spacing       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign weff      = (glow_width == '0) ? 16'd1 : glow_width;
  assign soft_raw  = tone_controls[17:9];
  assign thr_space = spacing * CORE_SPACE_K;
  assign thr_glow  = weff * CORE_GLOW_K;
  assign raise_full = spacing * core_mult(control[2:0]);

  // Registered, so they follow the registers in the next cycle; items reach the size stages much later.
  always_ff @(posedge clk) begin
    core_thresh <= (thr_space > thr_glow) ? thr_space : thr_glow;
    core_raise  <= (raise_full[33:16] > 18'd65535) ? 16'hFFFF : raise_full[31:16];
  end

  always_comb begin
    cfg.shape       = control[2:0];
    cfg.glow        = control[3];
    cfg.invert      = control[4];
    cfg.solid       = control[5];
    cfg.contain     = control[6];
    cfg.clip        = control[7];
    cfg.weff        = weff;
    cfg.strength    = tone_controls[8:0];
    cfg.softness    = (soft_raw > 9'd256) ? 9'd256 : soft_raw;
    cfg.gamma       = gamma;
    cfg.min_size    = min_size;
    cfg.max_size    = max_size;
    cfg.cull_size   = cull_size;
    cfg.core_thresh = core_thresh;
    cfg.core_raise  = core_raise;
  end
endmodule

FILE: rtl/hms_tone.sv
// Tone pipeline: drop checks, distance divide, smoothstep, softness and strength.
module hms_tone (
  input  logic           clk,
  input  logic           rst,
  input  hms_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [15:0]    d,
  input  logic           in_shape,
  input  logic           bounds,
  output logic           out_valid,
  input  logic           out_ready,
  output hms_pkg::dens_t out_data
);
  import hms_pkg::*;

  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS   = 4;
  localparam int SQ_IDX     = DIV_STAGES + 1;
  localparam int NT         = SQ_IDX + 5;

  typedef struct packed {
    side_t       side;
    logic [15:0] rem;
    logic [16:0] quot;
    logic [16:0] t;
    logic [25:0] a;
    logic [25:0] b;
    logic [16:0] den;
  } tn_t;

  tn_t           st [NT];
  logic [NT-1:0] v;
  logic [NT-1:0] en;

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else     v <= (v & ~en) | ({v[NT-2:0], in_valid} & en);
  end

  for (genvar i = 0; i < NT; i++) begin : g_stage
    tn_t nxt;

    assign en[i] = out_ready || !(&v[NT-1:i]);

    always_ff @(posedge clk) begin
      if (en[i]) st[i] <= nxt;
    end

    if (i == 0) begin : g_entry
      always_comb begin
        logic [15:0] dm;
        nxt = '0;
        nxt.side.d = d;
        if (!bounds)                       nxt.side.reason = DROP_BOUNDS;
        else if (cfg.glow ? in_shape : !in_shape) nxt.side.reason = DROP_SIDE;
        else if (cfg.glow && d > cfg.weff) nxt.side.reason = DROP_GLOW;
        else                               nxt.side.reason = DROP_NONE;
        dm = (d < cfg.weff) ? d : cfg.weff;
        // Integer bit of the quotient: set only when the distance reaches the width.
        if (dm == cfg.weff) begin
          nxt.quot = 17'd1;
          nxt.rem  = '0;
        end else begin
          nxt.quot = '0;
          nxt.rem  = dm;
        end
      end
    end else if (i <= DIV_STAGES) begin : g_div
      always_comb begin
        logic [16:0] r2;
        logic [15:0] rm;
        logic [16:0] qt;
        nxt = st[i-1];
        rm = st[i-1].rem;
        qt = st[i-1].quot;
        for (int k = 0; k < DIV_BITS; k++) begin
          r2 = {rm, 1'b0};
          if (r2 >= {1'b0, cfg.weff}) begin
            rm = 16'(r2 - {1'b0, cfg.weff});
            qt = {qt[15:0], 1'b1};
          end else begin
            rm = r2[15:0];
            qt = {qt[15:0], 1'b0};
          end
        end
        nxt.rem  = rm;
        nxt.quot = qt;
      end
    end else if (i == SQ_IDX) begin : g_square
      always_comb begin
        logic [16:0] tv;
        logic [33:0] sq;
        nxt = st[i-1];
        tv = cfg.glow ? 17'(ONE_Q16 - st[i-1].quot) : st[i-1].quot;
        sq = tv * tv;
        nxt.t = tv;
        nxt.a = 26'(sq[33:16]);
        nxt.b = 26'(18'd196608 - {tv, 1'b0});
      end
    end else if (i == SQ_IDX + 1) begin : g_smooth
      always_comb begin
        logic [35:0] pr;
        nxt = st[i-1];
        pr = st[i-1].a[17:0] * st[i-1].b[17:0];
        nxt.a = 26'(pr[35:16]);
      end
    end else if (i == SQ_IDX + 2) begin : g_soft_mul
      always_comb begin
        nxt = st[i-1];
        nxt.a = (9'd256 - cfg.softness) * st[i-1].t;
        nxt.b = cfg.softness * st[i-1].a[16:0];
      end
    end else if (i == SQ_IDX + 3) begin : g_soft_sum
      always_comb begin
        logic [26:0] sum;
        nxt = st[i-1];
        sum = {1'b0, st[i-1].a} + {1'b0, st[i-1].b};
        nxt.t = sum[24:8];
      end
    end else begin : g_strength
      always_comb begin
        logic [25:0] pg;
        logic [24:0] diff;
        nxt = st[i-1];
        pg = cfg.strength * 17'(ONE_Q16 - st[i-1].t);
        diff = 25'h100_0000 - pg[24:0];
        // Clamp at zero when the strength pulls density below nothing.
        nxt.den = (pg >= 26'h100_0000) ? '0 : diff[24:8];
      end
    end
  end

  assign in_ready      = en[0];
  assign out_valid     = v[NT-1];
  assign out_data.side = st[NT-1].side;
  assign out_data.den  = st[NT-1].den;
endmodule

FILE: rtl/hms_power.sv
// Gamma power pipeline: log2 by repeated squaring, exponent multiply, exp2 by roots.
module hms_power (
  input  logic           clk,
  input  logic           rst,
  input  hms_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  hms_pkg::dens_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hms_pkg::dens_t out_data
);
  import hms_pkg::*;

  localparam int LOG_STEPS = 16;
  localparam int EXP_STEPS = 16;
  localparam int E_IDX     = LOG_STEPS + 1;
  localparam int X0        = E_IDX + 1;
  localparam int NP        = X0 + EXP_STEPS + 1;

  typedef struct packed {
    side_t       side;
    logic        spec;
    logic [16:0] sval;   // density for the edge cases; result at the last stage
    logic [3:0]  p;
    logic [15:0] y;
    logic [15:0] frac;
    logic [24:0] e;
    logic        one;
    logic [31:0] prod;
  } pw_t;

  pw_t           st [NP];
  logic [NP-1:0] v;
  logic [NP-1:0] en;

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else     v <= (v & ~en) | ({v[NP-2:0], in_valid} & en);
  end

  for (genvar i = 0; i < NP; i++) begin : g_stage
    pw_t nxt;

    assign en[i] = out_ready || !(&v[NP-1:i]);

    always_ff @(posedge clk) begin
      if (en[i]) st[i] <= nxt;
    end

    if (i == 0) begin : g_norm
      always_comb begin
        logic [3:0] msb;
        nxt = '0;
        nxt.side = in_data.side;
        msb = '0;
        for (int b = 1; b < 16; b++) begin
          if (in_data.den[b]) msb = 4'(b);
        end
        nxt.p    = msb;
        nxt.y    = in_data.den[15:0] << (4'd15 - msb);
        nxt.spec = (in_data.den == '0) || in_data.den[16];
        nxt.sval = (in_data.den[16] || cfg.gamma == '0) ? ONE_Q16 : '0;
      end
    end else if (i < E_IDX) begin : g_log
      always_comb begin
        logic [31:0] sq;
        nxt = st[i-1];
        sq = st[i-1].y * st[i-1].y;
        if (sq[31]) begin
          nxt.y    = sq[31:16];
          nxt.frac = {st[i-1].frac[14:0], 1'b1};
        end else begin
          nxt.y    = sq[30:15];
          nxt.frac = {st[i-1].frac[14:0], 1'b0};
        end
      end
    end else if (i == E_IDX) begin : g_expo
      always_comb begin
        logic [20:0] lg;
        logic [32:0] pe;
        nxt = st[i-1];
        lg = {5'(5'd16 - {1'b0, st[i-1].p}), 16'h0} - {5'b0, st[i-1].frac};
        pe = lg * cfg.gamma;
        nxt.e    = pe[32:8];
        nxt.one  = 1'b1;
        nxt.prod = '0;
      end
    end else if (i < NP - 1) begin : g_exp
      localparam int N = i - X0;
      always_comb begin
        logic [63:0] mp;
        nxt = st[i-1];
        mp = st[i-1].prod * EXP_ROOT[N];
        if (st[i-1].e[15-N]) begin
          if (st[i-1].one) begin
            nxt.prod = EXP_ROOT[N];
            nxt.one  = 1'b0;
          end else begin
            nxt.prod = mp[63:32];
          end
        end
      end
    end else begin : g_final
      always_comb begin
        logic [8:0]  q;
        logic [32:0] full;
        logic [32:0] sh;
        logic [16:0] dn;
        nxt = st[i-1];
        q = st[i-1].e[24:16];
        full = {st[i-1].one, st[i-1].one ? 32'h0 : st[i-1].prod};
        sh = full >> (6'd16 + q[5:0]);
        if (st[i-1].spec)    dn = st[i-1].sval;
        else if (q >= 9'd48) dn = '0;
        else                 dn = sh[16:0];
        if (cfg.invert) dn = 17'(ONE_Q16 - dn);
        nxt.sval = dn;
      end
    end
  end

  assign in_ready      = en[0];
  assign out_valid     = v[NP-1];
  assign out_data.side = st[NP-1].side;
  assign out_data.den  = st[NP-1].sval;
endmodule

FILE: rtl/hms_size.sv
// Size pipeline: interpolation, solid core raise, cull, containment and output register.
module hms_size (
  input  logic           clk,
  input  logic           rst,
  input  hms_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  hms_pkg::dens_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    mark_size,
  output logic [2:0]     drop_reason
);
  import hms_pkg::*;

  localparam int NZ = 3;

  typedef struct packed {
    side_t       side;
    logic [32:0] pa;
    logic [32:0] pb;
    logic [16:0] lim;
    logic        hit;
    logic [15:0] size;
  } sz_t;

  sz_t           st [NZ];
  logic [NZ-1:0] v;
  logic [NZ-1:0] en;

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else     v <= (v & ~en) | ({v[NZ-2:0], in_valid} & en);
  end

  for (genvar i = 0; i < NZ; i++) begin : g_stage
    sz_t nxt;

    assign en[i] = out_ready || !(&v[NZ-1:i]);

    always_ff @(posedge clk) begin
      if (en[i]) st[i] <= nxt;
    end

    if (i == 0) begin : g_mul
      always_comb begin
        logic [32:0] lp;
        nxt = '0;
        nxt.side = in_data.side;
        nxt.pa = cfg.min_size * 17'(ONE_Q16 - in_data.den);
        nxt.pb = cfg.max_size * in_data.den;
        lp = in_data.side.d * SQUARE_LIM_K;
        nxt.lim = (cfg.shape == SHAPE_SQUARE) ? lp[32:16] : {in_data.side.d, 1'b0};
        nxt.hit = cfg.solid && !cfg.glow && ({in_data.side.d, 16'h0} >= cfg.core_thresh);
      end
    end else if (i == 1) begin : g_interp
      always_comb begin
        logic [33:0] sum;
        nxt = st[i-1];
        sum = {1'b0, st[i-1].pa} + {1'b0, st[i-1].pb};
        nxt.size = sum[31:16];
        if (st[i-1].hit && cfg.core_raise > sum[31:16]) nxt.size = cfg.core_raise;
      end
    end else begin : g_final
      always_comb begin
        logic [15:0] sz;
        nxt = st[i-1];
        sz = st[i-1].size;
        if (cfg.contain && !cfg.glow && !cfg.clip && st[i-1].lim < {1'b0, sz}) begin
          sz = st[i-1].lim[15:0];
        end
        if (st[i-1].side.reason != DROP_NONE) begin
          nxt.size = '0;
        end else if (cfg.cull_size != '0 && st[i-1].size < cfg.cull_size) begin
          nxt.size        = '0;
          nxt.side.reason = DROP_CULL;
        end else if (sz <= SMALL_LIMIT) begin
          nxt.size        = '0;
          nxt.side.reason = DROP_SMALL;
        end else begin
          nxt.size = sz;
        end
      end
    end
  end

  assign in_ready    = en[0];
  assign out_valid   = v[NZ-1];
  assign mark_size   = st[NZ-1].size;
  assign drop_reason = st[NZ-1].side.reason;
endmodule

FILE: rtl/halftone_mark_sizer_unit.sv
// A point passes through 48 stages on its way from the input to its mark.
// Throughput: one point per cycle; any empty stage lets a new point in while the
// output register waits; a stall holds each full stage with no empty stage after it.
// Depth is set by the gamma power: 16 log2 squaring steps and 16 exp2 root products,
// one 32-bit multiply per stage.
// Reset (synchronous, active high) empties the pipeline and restores register defaults.
module halftone_mark_sizer_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [hms_pkg::CFG_AW-1:0] cfg_index,
  input  logic [hms_pkg::CFG_DW-1:0] cfg_data,
  hms_point_if.sink                  point,
  hms_mark_if.source                 mark
);
  import hms_pkg::*;

  cfg_t  cfg;

  // Tone to power handoff
  logic  tone_valid;
  logic  tone_ready;
  dens_t tone_data;

  // Power to size handoff
  logic  pow_valid;
  logic  pow_ready;
  dens_t pow_data;

  // Registers and the derived core threshold and raise; the derived pair
  // settles in the cycle after a write, long before any point reaches them.
  hms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Drop checks for bounds, side and glow band; tone from distance over width,
  // smoothstep, softness blend and strength. Ten stages.
  hms_tone u_tone (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .d         (point.distance_to_edge),
    .in_shape  (point.point_inside),
    .bounds    (point.within_bounds),
    .out_valid (tone_valid),
    .out_ready (tone_ready),
    .out_data  (tone_data)
  );

  // Density raised to gamma and optionally inverted. Thirty-five stages.
  hms_power u_power (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (tone_valid),
    .in_ready  (tone_ready),
    .in_data   (tone_data),
    .out_valid (pow_valid),
    .out_ready (pow_ready),
    .out_data  (pow_data)
  );

  // Size range, solid core, cull, containment and the small-mark floor.
  // The last of its three stages is the output register.
  hms_size u_size (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (pow_valid),
    .in_ready    (pow_ready),
    .in_data     (pow_data),
    .out_valid   (mark.valid),
    .out_ready   (mark.ready),
    .mark_size   (mark.mark_size),
    .drop_reason (mark.drop_reason)
  );
endmodule

FILE: rtl/hms_checker.sv
// Port-level checks of the halftone mark sizer, bound to the top level.
module hms_checker (
  input logic        clk,
  input logic        rst,
  input logic        mark_valid,
  input logic        mark_ready,
  input logic [15:0] mark_size,
  input logic [2:0]  drop_reason
);
  import hms_pkg::*;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !mark_valid)
    else $error("mark valid right after reset");

  // A dropped point carries a zero size.
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    mark_valid && drop_reason != DROP_NONE |-> mark_size == '0)
    else $error("dropped mark with nonzero size");

  // An emitted mark is above the small-mark floor.
  a_emit_floor: assert property (@(posedge clk) disable iff (rst)
    mark_valid && drop_reason == DROP_NONE |-> mark_size > SMALL_LIMIT)
    else $error("emitted mark at or below the floor");

  // Only defined drop codes leave the block.
  a_reason_range: assert property (@(posedge clk) disable iff (rst)
    mark_valid |-> drop_reason <= DROP_SMALL)
    else $error("undefined drop reason");

  // A stalled transaction holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    mark_valid && !mark_ready |=> mark_valid && $stable(mark_size) && $stable(drop_reason))
    else $error("stalled mark changed");
endmodule

bind halftone_mark_sizer_unit hms_checker u_hms_checker (
  .clk         (clk),
  .rst         (rst),
  .mark_valid  (mark.valid),
  .mark_ready  (mark.ready),
  .mark_size   (mark.mark_size),
  .drop_reason (mark.drop_reason)
);
